// File: rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types and codes for the two-class oldest-first queue block.
// ----------------------------------------------------------------------------
package tcf_pkg;

    // command codes
    localparam logic [1:0] CMD_ENQ     = 2'd0;
    localparam logic [1:0] CMD_DEQ_A   = 2'd1;
    localparam logic [1:0] CMD_DEQ_B   = 2'd2;
    localparam logic [1:0] CMD_DEQ_ANY = 2'd3;

    // class codes for enqueue
    localparam logic [1:0] KIND_A = 2'd0;
    localparam logic [1:0] KIND_B = 2'd1;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_BADCLASS = 2'd3;

    localparam int ID_W    = 16;
    localparam int STAMP_W = 32;

    // input word
    typedef struct packed {
        logic [1:0]      cmd;
        logic [1:0]      kind;
        logic [ID_W-1:0] item_id;
    } t_in_item;

    // result word
    typedef struct packed {
        logic [ID_W-1:0] served_id;
        logic            served_kind;
        logic [1:0]      status;
    } t_out_item;

    // one stored queue entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // control from sequencer to one queue
    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
    } t_qctl;

    // status from one queue
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// File: rtl/two_class_fifo_oldest_first.sv
// Command flow: an accepted command is registered and the block enters
// ST_EXEC, where the result word is formed; it is then registered onto
// o_result with o_done. No new command is taken in ST_EXEC, which waits on
// the registered read of both head entries before the compare and update.
// Reset: synchronous active-low; both queues empty, stamp counter zero.
// Results are strobed for one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two id queues with arrival stamps; dequeue-any serves the older head.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first import tcf_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    t_state    r_state, n_state;
    t_in_item  r_item;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    t_out_item r_result, n_result;
    logic      r_done, n_done;

    t_qctl  ctl_a, ctl_b;
    t_qstat stat_a, stat_b;
    t_entry head_a, head_b, wentry;

    logic               accept;
    logic [STAMP_W-1:0] stamp_diff;
    logic               pick_b;

    assign busy   = (r_state == ST_EXEC) | ~i_rst_n;
    assign accept = start & ~busy;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stamp <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stamp <= n_stamp;
            r_done  <= n_done;
        end
    end

    // command and result words
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    // age compare of the two heads, modulo the stamp width
    assign stamp_diff = head_a.stamp - head_b.stamp;
    assign wentry     = '{id: r_item.item_id, stamp: r_stamp + 1'b1};

    // next state and queue control
    always_comb begin
        n_state  = r_state;
        n_stamp  = r_stamp;
        n_done   = 1'b0;
        n_result = r_result;
        ctl_a    = '{rd_en: accept, push: 1'b0, pop: 1'b0};
        ctl_b    = '{rd_en: accept, push: 1'b0, pop: 1'b0};
        pick_b   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state  = ST_IDLE;
                n_done   = 1'b1;
                n_result = '{served_id: '0, served_kind: 1'b0, status: STAT_OK};
                if (r_item.cmd == CMD_ENQ) begin
                    if (r_item.kind == KIND_A) begin
                        if (stat_a.full) begin
                            n_result.status = STAT_FULL;
                        end else begin
                            ctl_a.push = 1'b1;
                            n_stamp    = wentry.stamp;
                        end
                    end else if (r_item.kind == KIND_B) begin
                        if (stat_b.full) begin
                            n_result.status = STAT_FULL;
                        end else begin
                            ctl_b.push = 1'b1;
                            n_stamp    = wentry.stamp;
                        end
                    end else begin
                        n_result.status = STAT_BADCLASS;
                    end
                end else begin
                    // choose the class to serve
                    case (r_item.cmd)
                        CMD_DEQ_A: pick_b = 1'b0;
                        CMD_DEQ_B: pick_b = 1'b1;
                        CMD_DEQ_ANY: begin
                            if (stat_a.empty) begin
                                pick_b = 1'b1;
                            end else if (stat_b.empty) begin
                                pick_b = 1'b0;
                            end else begin
                                pick_b = (stamp_diff != '0) && !stamp_diff[STAMP_W-1];
                            end
                        end
                        default: pick_b = 1'b0;
                    endcase
                    if (pick_b) begin
                        if (stat_b.empty) begin
                            n_result.status = STAT_EMPTY;
                        end else begin
                            ctl_b.pop            = 1'b1;
                            n_result.served_id   = head_b.id;
                            n_result.served_kind = 1'b1;
                        end
                    end else begin
                        if (stat_a.empty) begin
                            n_result.status = STAT_EMPTY;
                        end else begin
                            ctl_a.pop          = 1'b1;
                            n_result.served_id = head_a.id;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // class A queue
    tcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .i_wdata (wentry),
        .o_head  (head_a),
        .o_stat  (stat_a)
    );

    // class B queue
    tcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_b),
        .i_wdata (wentry),
        .o_head  (head_b),
        .o_stat  (stat_b)
    );

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: rtl/tcf_ram.sv
// ----------------------------------------------------------------------------
// tcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tcf_queue.sv
// ----------------------------------------------------------------------------
// tcf_queue
// One circular queue: head, tail and count around an entry RAM.
// ----------------------------------------------------------------------------
module tcf_queue import tcf_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qctl  i_ctl,
    input  t_entry i_wdata,
    output t_entry o_head,
    output t_qstat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [$bits(t_entry)-1:0] rdata;

    // pointer and count update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail  = (r_tail == LAST) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_head  = (r_head == LAST) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // entry storage, read at head, written at tail
    tcf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_tail),
        .i_wdata (i_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign o_head      = t_entry'(rdata);
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_CNT);

endmodule
